// File: hdl/random_drift_fractional_delay_macros.svh
// Assertion macros shared by the drifting delay line modules.
`ifndef RANDOM_DRIFT_FRACTIONAL_DELAY_MACROS_SVH
`define RANDOM_DRIFT_FRACTIONAL_DELAY_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RDFD_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RDFD_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rdfd_pkg.sv
// Shared constants and controller/datapath interface types of the drifting delay line.
`default_nettype none
package rdfd_pkg;

  localparam int STORE_DEPTH_DEF   = 8192;
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int BASE_BITS = 21;
  localparam int GAIN_BITS = 32;
  localparam int SEED_BITS = 31;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [BASE_BITS-1:0] BASE_DELAY_RST     = 21'd256;
  localparam logic [GAIN_BITS-1:0] DRIFT_GAIN_RST     = 32'd0;
  localparam logic [GAIN_BITS-1:0] SMOOTHING_GAIN_RST = 32'd178957;
  localparam logic [SEED_BITS-1:0] NOISE_SEED_RST     = 31'd1;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_BASE_DELAY     = 2'd0;
  localparam logic [1:0] REG_DRIFT_GAIN     = 2'd1;
  localparam logic [1:0] REG_SMOOTHING_GAIN = 2'd2;
  localparam logic [1:0] REG_NOISE_SEED     = 2'd3;

  // Park-Miller minimal-standard generator.
  localparam logic [SEED_BITS-1:0] PM_MOD = 31'h7FFF_FFFF;
  localparam logic [14:0]          PM_MUL = 15'd16807;

  typedef struct packed {
    logic accept;    // write the sample, advance the write index
    logic clear;     // write zero at the clear counter
    logic pm_mul;    // noise state times the generator multiplier
    logic pm_red;    // reduce modulo 2^31-1
    logic diff;      // noise minus smoothed value, split into sign and magnitude
    logic mul_hi;    // upper magnitude part times smoothing gain
    logic mul_lo;    // lower magnitude part times smoothing gain
    logic step;      // update the smoothed value
    logic smag;      // magnitude of the smoothed value at 31 fraction bits
    logic sw_mul;    // magnitude times drift gain
    logic delay;     // form and clamp the delay
    logic pos;       // read position, integer part and fraction
    logic rd_a;      // read the first tap
    logic rd_b;      // read the second tap, capture the first
    logic mix;       // interpolate
    logic load_out;  // round into the output register
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/rdfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rdfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hdl/rdfd_ctrl.sv
// Sequencing state machine and output handshake of the drifting delay line.
`default_nettype none
`include "random_drift_fractional_delay_macros.svh"
module rdfd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire rdfd_pkg::status_t status,
  output rdfd_pkg::cmd_t         cmd
);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'b0000_0000_0000_0001,
    ST_CLEAR  = 16'b0000_0000_0000_0010,
    ST_PM_MUL = 16'b0000_0000_0000_0100,
    ST_PM_RED = 16'b0000_0000_0000_1000,
    ST_DIFF   = 16'b0000_0000_0001_0000,
    ST_MUL_HI = 16'b0000_0000_0010_0000,
    ST_MUL_LO = 16'b0000_0000_0100_0000,
    ST_STEP   = 16'b0000_0000_1000_0000,
    ST_SMAG   = 16'b0000_0001_0000_0000,
    ST_SW_MUL = 16'b0000_0010_0000_0000,
    ST_DELAY  = 16'b0000_0100_0000_0000,
    ST_POS    = 16'b0000_1000_0000_0000,
    ST_RD_A   = 16'b0001_0000_0000_0000,
    ST_RD_B   = 16'b0010_0000_0000_0000,
    ST_MIX    = 16'b0100_0000_0000_0000,
    ST_FIN    = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_accept;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_PM_MUL;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PM_MUL: begin cmd.pm_mul = 1'b1; state_nxt = ST_PM_RED; end
      ST_PM_RED: begin cmd.pm_red = 1'b1; state_nxt = ST_DIFF;   end
      ST_DIFF:   begin cmd.diff   = 1'b1; state_nxt = ST_MUL_HI; end
      ST_MUL_HI: begin cmd.mul_hi = 1'b1; state_nxt = ST_MUL_LO; end
      ST_MUL_LO: begin cmd.mul_lo = 1'b1; state_nxt = ST_STEP;   end
      ST_STEP:   begin cmd.step   = 1'b1; state_nxt = ST_SMAG;   end
      ST_SMAG:   begin cmd.smag   = 1'b1; state_nxt = ST_SW_MUL; end
      ST_SW_MUL: begin cmd.sw_mul = 1'b1; state_nxt = ST_DELAY;  end
      ST_DELAY:  begin cmd.delay  = 1'b1; state_nxt = ST_POS;    end
      ST_POS:    begin cmd.pos    = 1'b1; state_nxt = ST_RD_A;   end
      ST_RD_A:   begin cmd.rd_a   = 1'b1; state_nxt = ST_RD_B;   end
      ST_RD_B:   begin cmd.rd_b   = 1'b1; state_nxt = ST_MIX;    end
      ST_MIX:    begin cmd.mix    = 1'b1; state_nxt = ST_FIN;    end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `RDFD_CHK_NEXT(a_accept_starts_item, in_accept, state_r == ST_PM_MUL,
                 "accepted item did not start the generator step")
  `RDFD_CHK_NEXT(a_fin_returns_idle, (state_r == ST_FIN) && out_free,
                 (state_r == ST_IDLE) && out_valid_r,
                 "finished item did not reach the output register")

endmodule
`default_nettype wire

// File: hdl/rdfd_dp.sv
// Datapath of the drifting delay line: generator, smoother, delay and interpolator.
`default_nettype none
`include "random_drift_fractional_delay_macros.svh"
module rdfd_dp #(
  parameter int STORE_DEPTH   = rdfd_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS   = rdfd_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = rdfd_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rdfd_pkg::cmd_t                   cmd,
  output rdfd_pkg::status_t                     status,
  input  wire logic [SAMPLE_BITS-1:0]           sample_in,
  output logic      [SAMPLE_BITS-1:0]           sample_out,
  input  wire logic [rdfd_pkg::BASE_BITS-1:0]   base_delay,
  input  wire logic [rdfd_pkg::GAIN_BITS-1:0]   drift_gain,
  input  wire logic [rdfd_pkg::GAIN_BITS-1:0]   smoothing_gain,
  input  wire logic                             seed_load,
  input  wire logic [rdfd_pkg::SEED_BITS-1:0]   seed_value
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int F  = FRACTION_BITS;
  localparam int PW = AW + F + 1;
  localparam int YW = SAMPLE_BITS + F + 2;
  localparam logic [PW-1:0] TOTAL  = PW'(STORE_DEPTH) << F;
  localparam logic [PW-1:0] LO_LIM = PW'(1) << F;
  localparam logic [PW-1:0] HI_LIM = PW'(STORE_DEPTH - 2) << F;
  localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);

  // Control-side counters.
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Payload registers.
  logic [rdfd_pkg::SEED_BITS-1:0] noise_r, noise_nxt;
  logic signed [47:0]             smooth_r, smooth_nxt;
  logic [63:0]                    prod_r;
  logic [56:0]                    acc_r;
  logic [48:0]                    mag_r;
  logic                           diff_neg_r;
  logic [31:0]                    smag_r;
  logic                           sw_neg_r;
  logic [PW-1:0]                  delay_r;
  logic [AW-1:0]                  idx_r, idx1_r;
  logic [F-1:0]                   frac_r;
  logic signed [SAMPLE_BITS-1:0]  tap_a_r;
  logic signed [YW-1:0]           y_r;
  logic [SAMPLE_BITS-1:0]         out_r;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = smag_r;
    mul_b = drift_gain;
    case (1'b1)
      cmd.pm_mul: begin
        mul_a = {1'b0, noise_r};
        mul_b = {17'b0, rdfd_pkg::PM_MUL};
      end
      cmd.mul_hi: begin
        mul_a = {7'b0, mag_r[48:24]};
        mul_b = smoothing_gain;
      end
      cmd.mul_lo: begin
        mul_a = {8'b0, mag_r[23:0]};
        mul_b = smoothing_gain;
      end
      default: begin
        mul_a = smag_r;
        mul_b = drift_gain;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Modulo 2^31-1 by folding the high part onto the low part.
  logic [31:0] pm_sum;
  logic [31:0] pm_red;
  assign pm_sum = {17'b0, prod_r[45:31]} + {1'b0, prod_r[30:0]};
  assign pm_red = (pm_sum >= {1'b0, rdfd_pkg::PM_MOD}) ?
                  pm_sum - {1'b0, rdfd_pkg::PM_MOD} : pm_sum;

  always_comb begin
    noise_nxt = noise_r;
    if (seed_load) begin
      noise_nxt = seed_value;
    end else if (cmd.pm_red) begin
      noise_nxt = pm_red[30:0];
    end
  end

  // Noise mapped to [-1,1) with 47 fraction bits, minus the smoothed value.
  logic signed [32:0] noise31;
  logic signed [49:0] diff;
  assign noise31 = $signed({1'b0, noise_r, 1'b0}) - $signed({1'b0, 32'h8000_0000});
  assign diff    = $signed({{1{noise31[32]}}, noise31, 16'b0}) -
                   $signed({{2{smooth_r[47]}}, smooth_r});

  // Step of the one-pole filter.
  logic [57:0]        step_sum;
  logic [49:0]        step_mag;
  logic signed [49:0] smooth_ext;
  assign step_sum   = {1'b0, acc_r} + {26'b0, prod_r[55:24]};
  assign step_mag   = step_sum[57:8];
  assign smooth_ext = $signed({{2{smooth_r[47]}}, smooth_r});

  always_comb begin
    smooth_nxt = smooth_r;
    if (cmd.step) begin
      smooth_nxt = diff_neg_r ? 48'(smooth_ext - $signed(step_mag)) :
                                48'(smooth_ext + $signed(step_mag));
    end
  end

  // Smoothed value at 31 fraction bits, floor shift.
  logic signed [31:0] s31;
  assign s31 = 32'(smooth_r >>> 16);

  // Rounded swing, signed delay and clamp.
  logic [63:0]        sw_round;
  logic [32:0]        swing;
  logic signed [34:0] dly;
  logic signed [34:0] lo_ext, hi_ext;
  logic [PW-1:0]      dly_clamped;
  assign sw_round = prod_r + 64'h0000_0000_4000_0000;
  assign swing    = sw_round[63:31];
  assign dly      = sw_neg_r ?
                    $signed({14'b0, base_delay}) - $signed({2'b0, swing}) :
                    $signed({14'b0, base_delay}) + $signed({2'b0, swing});
  assign lo_ext   = $signed(35'(LO_LIM));
  assign hi_ext   = $signed(35'(HI_LIM));
  always_comb begin
    if (dly < lo_ext) begin
      dly_clamped = LO_LIM;
    end else if (dly > hi_ext) begin
      dly_clamped = HI_LIM;
    end else begin
      dly_clamped = PW'(dly);
    end
  end

  // Read position behind the write index.
  logic [PW:0]   pos_sum;
  logic [PW-1:0] pos;
  assign pos_sum = (PW+1)'({wr_idx_r, {F{1'b0}}}) + (PW+1)'(TOTAL) - (PW+1)'(delay_r);
  assign pos     = (pos_sum >= (PW+1)'(TOTAL)) ? PW'(pos_sum - (PW+1)'(TOTAL)) :
                                                 PW'(pos_sum);

  // Delay store.
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  assign ram_we    = cmd.accept || cmd.clear;
  assign ram_waddr = cmd.clear ? clr_cnt_r : wr_idx_r;
  assign ram_wdata = cmd.clear ? '0 : sample_in;
  assign ram_raddr = cmd.rd_a ? idx_r : idx1_r;

  rdfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Interpolation and rounding.
  logic signed [SAMPLE_BITS:0] tap_d;
  logic signed [YW-1:0]        mix_y;
  logic signed [YW-1:0]        y_rnd;
  assign tap_d = $signed({ram_rdata[SAMPLE_BITS-1], ram_rdata}) -
                 $signed({tap_a_r[SAMPLE_BITS-1], tap_a_r});
  assign mix_y = ($signed(YW'(tap_a_r)) <<< F) + YW'(tap_d * $signed({1'b0, frac_r}));
  assign y_rnd = (y_r + $signed(YW'(1) << (F - 1))) >>> F;

  // Counters.
  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.accept) begin
      wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
    end
    if (cmd.clear) begin
      clr_cnt_nxt = (clr_cnt_r == LAST_IDX) ? '0 : clr_cnt_r + 1'b1;
    end
  end

  assign status.clear_done = cmd.clear && (clr_cnt_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      clr_cnt_r <= '0;
      noise_r   <= rdfd_pkg::NOISE_SEED_RST;
      smooth_r  <= '0;
    end else begin
      wr_idx_r  <= wr_idx_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      noise_r   <= noise_nxt;
      smooth_r  <= smooth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pm_mul || cmd.mul_hi || cmd.mul_lo || cmd.sw_mul) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_lo) begin
      acc_r <= prod_r[56:0];
    end
    if (cmd.diff) begin
      diff_neg_r <= diff[49];
      mag_r      <= diff[49] ? 49'(-diff) : diff[48:0];
    end
    if (cmd.smag) begin
      sw_neg_r <= s31[31];
      smag_r   <= s31[31] ? 32'(-s31) : 32'(s31);
    end
    if (cmd.delay) begin
      delay_r <= dly_clamped;
    end
    if (cmd.pos) begin
      idx_r  <= pos[F +: AW];
      frac_r <= pos[F-1:0];
    end
    if (cmd.rd_a) begin
      idx1_r <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    end
    if (cmd.rd_b) begin
      tap_a_r <= $signed(ram_rdata);
    end
    if (cmd.mix) begin
      y_r <= mix_y;
    end
    if (cmd.load_out) begin
      out_r <= y_rnd[SAMPLE_BITS-1:0];
    end
  end

  assign sample_out = out_r;

  `RDFD_CHK_NOW(a_noise_live, 1'b1,
                (noise_r != '0) && (noise_r != rdfd_pkg::PM_MOD),
                "generator state reached a locking value")
  `RDFD_CHK_NEXT(a_delay_clamped, cmd.delay,
                 (delay_r >= LO_LIM) && (delay_r <= HI_LIM),
                 "delay left its clamp range")

endmodule
`default_nettype wire

// File: hdl/random_drift_fractional_delay.sv
// Top level of the randomly drifting fractional delay line with linear interpolation.
// An accepted item walks the sequencer states, and its result is loaded into the output register;
// a new item is accepted only after that, as every item passes through one shared multiplier.
// An item may be accepted while the previous result still waits in the output register.
// Reset (synchronous, rst_n low) loads the register defaults and then clears the delay store,
// one entry per cycle until all STORE_DEPTH entries are zero, during which no item is accepted.
`default_nettype none
module random_drift_fractional_delay #(
  parameter int STORE_DEPTH   = rdfd_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS   = rdfd_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = rdfd_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Input stream. in_tdata: sample_in (signed), zero padding above.
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  // Result stream. out_tdata: sample_out (signed), zero padding above.
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]       out_tdata,
  // Register port.
  input  wire logic                                   cfg_psel,
  input  wire logic                                   cfg_penable,
  input  wire logic                                   cfg_pwrite,
  input  wire logic [rdfd_pkg::ADDR_BITS-1:0]         cfg_paddr,
  input  wire logic [rdfd_pkg::DATA_BITS-1:0]         cfg_pwdata,
  output logic      [rdfd_pkg::DATA_BITS-1:0]         cfg_prdata,
  output logic                                        cfg_pready
);

  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

  // Configuration registers. Writing the seed also reloads the generator state;
  // a seed of zero or of 2^31-1 would lock the generator and is loaded as one.
  logic [rdfd_pkg::BASE_BITS-1:0] base_delay_r, base_delay_nxt;
  logic [rdfd_pkg::GAIN_BITS-1:0] drift_gain_r, drift_gain_nxt;
  logic [rdfd_pkg::GAIN_BITS-1:0] smoothing_gain_r, smoothing_gain_nxt;
  logic [rdfd_pkg::SEED_BITS-1:0] noise_seed_r, noise_seed_nxt;
  logic                           cfg_write;
  logic [1:0]                     cfg_index;
  logic                           seed_load;
  logic [rdfd_pkg::SEED_BITS-1:0] seed_raw;
  logic [rdfd_pkg::SEED_BITS-1:0] seed_clean;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[3:2];
  assign seed_raw   = cfg_pwdata[rdfd_pkg::SEED_BITS-1:0];
  assign seed_clean = ((seed_raw == '0) || (seed_raw == rdfd_pkg::PM_MOD)) ?
                      rdfd_pkg::NOISE_SEED_RST : seed_raw;
  assign seed_load  = cfg_write && (cfg_index == rdfd_pkg::REG_NOISE_SEED);

  always_comb begin
    base_delay_nxt     = base_delay_r;
    drift_gain_nxt     = drift_gain_r;
    smoothing_gain_nxt = smoothing_gain_r;
    noise_seed_nxt     = noise_seed_r;
    if (cfg_write) begin
      case (cfg_index)
        rdfd_pkg::REG_BASE_DELAY:     base_delay_nxt     = cfg_pwdata[rdfd_pkg::BASE_BITS-1:0];
        rdfd_pkg::REG_DRIFT_GAIN:     drift_gain_nxt     = cfg_pwdata;
        rdfd_pkg::REG_SMOOTHING_GAIN: smoothing_gain_nxt = cfg_pwdata;
        rdfd_pkg::REG_NOISE_SEED:     noise_seed_nxt     = seed_raw;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delay_r     <= rdfd_pkg::BASE_DELAY_RST;
      drift_gain_r     <= rdfd_pkg::DRIFT_GAIN_RST;
      smoothing_gain_r <= rdfd_pkg::SMOOTHING_GAIN_RST;
      noise_seed_r     <= rdfd_pkg::NOISE_SEED_RST;
    end else begin
      base_delay_r     <= base_delay_nxt;
      drift_gain_r     <= drift_gain_nxt;
      smoothing_gain_r <= smoothing_gain_nxt;
      noise_seed_r     <= noise_seed_nxt;
    end
  end

  // Register read back, zero-extended to the bus width.
  always_comb begin
    case (cfg_index)
      rdfd_pkg::REG_BASE_DELAY:     cfg_prdata = 32'(base_delay_r);
      rdfd_pkg::REG_DRIFT_GAIN:     cfg_prdata = drift_gain_r;
      rdfd_pkg::REG_SMOOTHING_GAIN: cfg_prdata = smoothing_gain_r;
      rdfd_pkg::REG_NOISE_SEED:     cfg_prdata = 32'(noise_seed_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // The controller walks each item through the generator, the smoothing filter, the delay
  // computation, two store reads and the interpolation; the datapath does the arithmetic.
  rdfd_pkg::cmd_t         cmd;
  rdfd_pkg::status_t      status;
  logic [SAMPLE_BITS-1:0] sample_out;

  rdfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  rdfd_dp #(
    .STORE_DEPTH   (STORE_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .sample_in      (in_tdata[SAMPLE_BITS-1:0]),
    .sample_out     (sample_out),
    .base_delay     (base_delay_r),
    .drift_gain     (drift_gain_r),
    .smoothing_gain (smoothing_gain_r),
    .seed_load      (seed_load),
    .seed_value     (seed_clean)
  );

  assign out_tdata = TDW'(sample_out);

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the randomly drifting fractional delay line.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdfd_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam int SBITS = SAMPLE_BITS_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam int TBITS = ((SBITS + 7) / 8) * 8;
  // Cycles from an accepted item to its result when the output register is free.
  localparam int PIPE_LATENCY = 14;
  // The store clear after reset writes all DEPTH entries while no item moves.
  localparam int WATCHDOG = 4 * DEPTH + 1000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 200;

  localparam logic [SBITS-1:0] MAX_POS = {1'b0, {(SBITS-1){1'b1}}};
  localparam logic [SBITS-1:0] MAX_NEG = {1'b1, {(SBITS-1){1'b0}}};

  // Bit-accurate model of the delay line plus the queue of samples it still owes.
  class delay_line_scoreboard;
    logic signed [SBITS-1:0] history [DEPTH];
    int unsigned wr_ptr;
    longint smooth_q47;
    bit [SEED_BITS-1:0] pm_state;
    bit [BASE_BITS-1:0] base_delay;
    bit [GAIN_BITS-1:0] drift_gain;
    bit [GAIN_BITS-1:0] smoothing_gain;
    logic [SBITS-1:0] expected_outputs [$];
    int errors;
    int items_in;
    int results_out;
    int clamp_lo;
    int clamp_hi;

    function new();
      foreach (history[i]) history[i] = '0;
      wr_ptr = 0;
      smooth_q47 = 0;
      base_delay = BASE_DELAY_RST;
      drift_gain = DRIFT_GAIN_RST;
      smoothing_gain = SMOOTHING_GAIN_RST;
      pm_state = legal_seed(NOISE_SEED_RST);
      errors = 0;
      items_in = 0;
      results_out = 0;
      clamp_lo = 0;
      clamp_hi = 0;
    endfunction

    // A seed of all zeros or all ones would lock the generator.
    function bit [SEED_BITS-1:0] legal_seed(bit [SEED_BITS-1:0] s);
      return (s == '0 || s == '1) ? 1 : s;
    endfunction

    // Bits above each register's width are dropped; the seed loads the generator at once.
    function void set_register(logic [1:0] idx, logic [DATA_BITS-1:0] value);
      case (idx)
        REG_BASE_DELAY: base_delay = value[BASE_BITS-1:0];
        REG_DRIFT_GAIN: drift_gain = value[GAIN_BITS-1:0];
        REG_SMOOTHING_GAIN: smoothing_gain = value[GAIN_BITS-1:0];
        REG_NOISE_SEED: pm_state = legal_seed(value[SEED_BITS-1:0]);
        default: ;
      endcase
    endfunction

    // Stores the accepted sample and queues the interpolated sample it must produce.
    function void add_input(logic [SBITS-1:0] smp);
      bit [63:0] pm_next;
      logic [95:0] prod;
      longint noise_q47, diff, stepv, s31, delay, pos, a, b, y;
      longint unsigned mag, swing;
      longint lo_lim, hi_lim, span;
      int unsigned idx, idx1;
      lo_lim = longint'(1) <<< FRAC;
      hi_lim = longint'(DEPTH - 2) <<< FRAC;
      span = longint'(DEPTH) <<< FRAC;

      history[wr_ptr] = smp;
      wr_ptr = (wr_ptr + 1) % DEPTH;

      // Park-Miller step, then noise in [-1,1) as Q1.47.
      pm_next = (64'(pm_state) * 64'(PM_MUL)) % 64'(PM_MOD);
      pm_state = pm_next[SEED_BITS-1:0];
      noise_q47 = (2 * longint'(pm_state) - 64'sd2147483648) * 65536;

      // One-pole smoothing; the step magnitude is truncated before the sign goes back on.
      diff = noise_q47 - smooth_q47;
      mag = (diff < 0) ? -diff : diff;
      prod = mag * smoothing_gain;
      stepv = prod[95:32];
      smooth_q47 = smooth_q47 + ((diff < 0) ? -stepv : stepv);

      // Swing rounds half up in magnitude.
      s31 = smooth_q47 >>> 16;
      mag = (s31 < 0) ? -s31 : s31;
      swing = (mag * 64'(drift_gain) + 64'h4000_0000) >> 31;
      delay = longint'(base_delay) + ((s31 < 0) ? -longint'(swing) : longint'(swing));
      if (delay < lo_lim) begin
        delay = lo_lim;
        clamp_lo++;
      end
      if (delay > hi_lim) begin
        delay = hi_lim;
        clamp_hi++;
      end

      pos = (longint'(wr_ptr) <<< FRAC) + span - delay;
      if (pos >= span) pos = pos - span;
      idx = int'(pos >>> FRAC) % DEPTH;
      idx1 = (idx + 1) % DEPTH;
      a = history[idx];
      b = history[idx1];
      y = a * (longint'(1) <<< FRAC) + (b - a) * (pos & ((longint'(1) <<< FRAC) - 1));
      y = (y + (longint'(1) <<< (FRAC - 1))) >>> FRAC;

      expected_outputs.push_back(y[SBITS-1:0]);
      items_in++;
    endfunction

    function void check_result(logic [SBITS-1:0] got);
      logic [SBITS-1:0] want;
      results_out++;
      if (expected_outputs.size() == 0) begin
        errors++;
        $display("%0t: sample_out %0d arrived with no item outstanding, expected nothing",
                 $time, $signed(got));
      end else begin
        want = expected_outputs.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: sample_out mismatch on result %0d, expected %0d, actual %0d",
                   $time, results_out, $signed(want), $signed(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TBITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TBITS-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_BITS-1:0] cfg_paddr = '0;
  logic [DATA_BITS-1:0] cfg_pwdata = '0;
  logic [DATA_BITS-1:0] cfg_prdata;
  logic cfg_pready;

  delay_line_scoreboard sb;
  // Both sides insert random waits while this is set; some phases run at full rate.
  bit idle_on = 1'b0;
  int out_hold = 0;
  int quiet_cycles = 0;
  int settings_used = 0;

  random_drift_fractional_delay u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // sample_in (signed), zero padding above
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // sample_out (signed), zero padding above
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Input monitor and watchdog. Signals are sampled at the rising edge, before the
  // nonblocking updates of that edge land, so every process sees the same values.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.add_input(in_tdata[SBITS-1:0]);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: no item moved for %0d cycles, %0d results still owed",
               $time, WATCHDOG, sb.expected_outputs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check each result, then stall randomly while idle_on is set.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata[SBITS-1:0]);
      out_hold = idle_on ? $urandom_range(0, 6) : 0;
    end else if (out_hold > 0) begin
      out_hold = out_hold - 1;
    end
    out_tready <= rst_n && (out_hold == 0);
  end

  // Offers one item, after a random gap while idle_on is set, and returns at the edge where it is taken.
  // tvalid stays high afterwards so back-to-back items need no extra assignment.
  task automatic send_item(input logic [SBITS-1:0] smp);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= TBITS'(smp);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops the input stream and waits until every owed result has come back.
  // The first edge lets the monitor record an item taken at the current edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_outputs.size() != 0) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle. psel stays high so writes
  // can follow back to back; the caller closes the transfer.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // Every item yields a result, so the block is idle once nothing is owed.
  task automatic configure(input logic [DATA_BITS-1:0] base, drift, gain, seed);
    drain();
    write_reg(REG_BASE_DELAY, base);
    write_reg(REG_DRIFT_GAIN, drift);
    write_reg(REG_SMOOTHING_GAIN, gain);
    write_reg(REG_NOISE_SEED, seed);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    settings_used++;
  endtask

  // Mostly full-range samples, with the extremes and small values mixed in.
  function automatic logic [SBITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return MAX_POS;
      1: return MAX_NEG;
      2: return SBITS'(int'($urandom_range(0, 512)) - 256);
      default: return SBITS'($urandom());
    endcase
  endfunction

  // A random register setting followed by a block of random samples. Most settings
  // keep the delay within a few hundred samples so reads land on written data.
  task automatic random_phase(input int phase);
    logic [DATA_BITS-1:0] base, drift, gain, seed;
    case ($urandom_range(0, 7))
      0: base = 0;
      1: base = $urandom() | 32'h0020_0000;
      2: base = 256;
      3: base = 2096640;
      default: base = $urandom_range(256, 256 * 300);
    endcase
    case ($urandom_range(0, 6))
      0: drift = 0;
      1: drift = 32'hFFFF_FFFF;
      2: drift = $urandom();
      default: drift = $urandom_range(0, 256 * 100);
    endcase
    case ($urandom_range(0, 6))
      0: gain = 0;
      1: gain = 32'hFFFF_FFFF;
      2: gain = SMOOTHING_GAIN_RST;
      default: gain = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0: seed = 0;
      1: seed = 32'h7FFF_FFFF;
      2: seed = 32'h8000_0000 | $urandom();
      default: seed = $urandom();
    endcase
    configure(base, drift, gain, seed);
    idle_on = (phase % 4 != 3);
    for (int i = 0; i < PHASE_ITEMS; i++) send_item(rand_sample());
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: exactly one sample of delay and no drift, so each result is
    // the sample just written. The first item also waits out the store clear.
    send_item(MAX_POS);
    send_item(MAX_NEG);
    send_item('0);
    send_item('1);
    send_item(SBITS'(1));
    send_item(SBITS'(24'h40_0000));

    // Half a sample of fraction: rounding ties between opposite extremes, the
    // fastest smoothing, and a zero seed that must load as one.
    configure(32'h180, 0, 32'hFFFF_FFFF, 0);
    idle_on = 1'b1;
    send_item(MAX_POS);
    send_item(MAX_NEG);
    send_item(MAX_POS);
    send_item(MAX_NEG);
    send_item(SBITS'(1));
    send_item('1);

    // Base delay with bits above its width and full drift gain: the delay saturates at
    // the top of the store or at one sample. The all-ones seed must also load as one.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(MAX_NEG);
    send_item(MAX_POS);
    send_item(SBITS'(24'h12_3456));
    send_item(SBITS'(24'hED_CBA9));
    send_item('0);

    // Zero base delay saturates at one sample; the seed's dropped top bit leaves zero.
    configure(0, 0, 0, 32'h8000_0000);
    send_item(SBITS'(24'h55_5555));
    send_item(SBITS'(24'hAA_AAAA));
    send_item(MAX_POS);
    send_item(MAX_NEG);

    // Fractional base with full swing in both directions and the largest valid seed.
    configure(256 * 40 + 32'h55, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFE);
    send_item(MAX_POS);
    send_item(SBITS'(24'h00_0FFF));
    send_item(MAX_NEG);
    send_item(SBITS'(24'hFF_F000));

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

    drain();
    // Any stray result would show up during this wait.
    repeat (4 * PIPE_LATENCY) @(posedge clk);

    $display("Sent %0d items under %0d register settings and checked %0d results.",
             sb.items_in, settings_used + 1, sb.results_out);
    $display("Delay held at one sample %0d times and at the store limit %0d times; %0d errors.",
             sb.clamp_lo, sb.clamp_hi, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/rdfd_pkg.sv
hdl/rdfd_ram.sv
hdl/rdfd_ctrl.sv
hdl/rdfd_dp.sv
hdl/random_drift_fractional_delay.sv
verif/tb_top.sv
